// ----- rtl/tgl_pkg.sv -----
// Shared types, register map and constants for the text glyph layout block.
`default_nettype none

package tgl_pkg;

   localparam int QUEUE_DEPTH = 2;
   localparam int PADDR_WIDTH = 5;
   localparam int PDATA_WIDTH = 32;

   localparam logic [7:0] NEWLINE_CODE = 8'd10;
   localparam logic [7:0] COL_MAX      = 8'd255;
   localparam logic [8:0] ROW_MAX      = 9'd511;

   localparam logic [6:0]  CHAR_WIDTH_RESET     = 7'd8;
   localparam logic [6:0]  CHAR_HEIGHT_RESET    = 7'd8;
   localparam logic [8:0]  GLYPHS_PER_ROW_RESET = 9'd16;
   localparam logic [11:0] ORIGIN_X_RESET       = 12'd0;
   localparam logic [11:0] ORIGIN_Y_RESET       = 12'd0;
   localparam logic [7:0]  COLUMNS_RESET        = 8'd40;
   localparam logic [7:0]  ROW_LIMIT_RESET      = 8'd25;
   localparam logic [7:0]  FIRST_GLYPH_RESET    = 8'd32;

   typedef enum logic [2:0] {
      CSR_CHAR_WIDTH     = 3'd0,
      CSR_CHAR_HEIGHT    = 3'd1,
      CSR_GLYPHS_PER_ROW = 3'd2,
      CSR_ORIGIN_X       = 3'd3,
      CSR_ORIGIN_Y       = 3'd4,
      CSR_COLUMNS        = 3'd5,
      CSR_ROW_LIMIT      = 3'd6,
      CSR_FIRST_GLYPH    = 3'd7
   } csr_addr_type;

   typedef struct packed {
      logic [6:0]  char_width;
      logic [6:0]  char_height;
      logic [8:0]  glyphs_per_row;
      logic [11:0] origin_x;
      logic [11:0] origin_y;
      logic [7:0]  columns;
      logic [7:0]  row_limit;
      logic [7:0]  first_glyph;
   } cfg_type;

   typedef struct packed {
      logic [7:0] code;
      logic       text_start;
   } req_type;

   typedef struct packed {
      logic [13:0] src_x;
      logic [13:0] src_y;
      logic [14:0] dst_x;
      logic [14:0] dst_y;
   } rsp_type;

   // One glyph to draw, as classified by the front end.
   typedef struct packed {
      logic [7:0] glyph;
      logic [7:0] col;
      logic [8:0] row;
   } work_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

endpackage

`default_nettype wire

// ----- rtl/tgl_csr.sv -----
// Configuration register file with an APB-style access port.
`default_nettype none

module tgl_csr (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              psel,
   input  wire logic                              penable,
   input  wire logic                              pwrite,
   input  wire logic [tgl_pkg::PADDR_WIDTH-1:0]   paddr,
   input  wire logic [tgl_pkg::PDATA_WIDTH-1:0]   pwdata,
   output logic      [tgl_pkg::PDATA_WIDTH-1:0]   prdata,
   output logic                                   pready,
   output tgl_pkg::cfg_type                       cfg
);

   tgl_pkg::cfg_type     cfg_ff;
   tgl_pkg::csr_addr_type addr;
   logic                 wr_en;

   assign addr   = tgl_pkg::csr_addr_type'(paddr[4:2]);
   assign wr_en  = psel & penable & pwrite;
   assign pready = 1'b1;
   assign cfg    = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.char_width     <= tgl_pkg::CHAR_WIDTH_RESET;
         cfg_ff.char_height    <= tgl_pkg::CHAR_HEIGHT_RESET;
         cfg_ff.glyphs_per_row <= tgl_pkg::GLYPHS_PER_ROW_RESET;
         cfg_ff.origin_x       <= tgl_pkg::ORIGIN_X_RESET;
         cfg_ff.origin_y       <= tgl_pkg::ORIGIN_Y_RESET;
         cfg_ff.columns        <= tgl_pkg::COLUMNS_RESET;
         cfg_ff.row_limit      <= tgl_pkg::ROW_LIMIT_RESET;
         cfg_ff.first_glyph    <= tgl_pkg::FIRST_GLYPH_RESET;
      end else if (wr_en) begin
         unique case (addr)
            tgl_pkg::CSR_CHAR_WIDTH:     cfg_ff.char_width     <= pwdata[6:0];
            tgl_pkg::CSR_CHAR_HEIGHT:    cfg_ff.char_height    <= pwdata[6:0];
            tgl_pkg::CSR_GLYPHS_PER_ROW: cfg_ff.glyphs_per_row <= pwdata[8:0];
            tgl_pkg::CSR_ORIGIN_X:       cfg_ff.origin_x       <= pwdata[11:0];
            tgl_pkg::CSR_ORIGIN_Y:       cfg_ff.origin_y       <= pwdata[11:0];
            tgl_pkg::CSR_COLUMNS:        cfg_ff.columns        <= pwdata[7:0];
            tgl_pkg::CSR_ROW_LIMIT:      cfg_ff.row_limit      <= pwdata[7:0];
            tgl_pkg::CSR_FIRST_GLYPH:    cfg_ff.first_glyph    <= pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (addr)
         tgl_pkg::CSR_CHAR_WIDTH:     prdata = 32'(cfg_ff.char_width);
         tgl_pkg::CSR_CHAR_HEIGHT:    prdata = 32'(cfg_ff.char_height);
         tgl_pkg::CSR_GLYPHS_PER_ROW: prdata = 32'(cfg_ff.glyphs_per_row);
         tgl_pkg::CSR_ORIGIN_X:       prdata = 32'(cfg_ff.origin_x);
         tgl_pkg::CSR_ORIGIN_Y:       prdata = 32'(cfg_ff.origin_y);
         tgl_pkg::CSR_COLUMNS:        prdata = 32'(cfg_ff.columns);
         tgl_pkg::CSR_ROW_LIMIT:      prdata = 32'(cfg_ff.row_limit);
         tgl_pkg::CSR_FIRST_GLYPH:    prdata = 32'(cfg_ff.first_glyph);
         default:                     prdata = '0;
      endcase
   end

endmodule

`default_nettype wire

// ----- rtl/tgl_front.sv -----
// Front end: cursor tracking and classification of each incoming character.
`default_nettype none

module tgl_front (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire tgl_pkg::cfg_type     cfg,
   input  wire logic                 push,
   input  wire tgl_pkg::req_type     req_word,
   input  wire tgl_pkg::q_status_type q_status,
   output logic                      q_push,
   output tgl_pkg::work_type         q_word
);

   logic [7:0] cursor_col_ff, cursor_col_in;
   logic [8:0] cursor_row_ff, cursor_row_in;
   logic       after_newline_ff, after_newline_in;
   logic       halted_ff, halted_in;
   logic       accept;
   logic       emit;
   logic       swallow;

   assign accept = push & ~q_status.full;
   assign q_push = accept & emit;

   always_comb begin
      cursor_col_in    = cursor_col_ff;
      cursor_row_in    = cursor_row_ff;
      after_newline_in = after_newline_ff;
      halted_in        = halted_ff;
      emit             = 1'b0;
      swallow          = 1'b0;
      q_word           = '0;

      if (req_word.text_start) begin
         cursor_col_in    = '0;
         cursor_row_in    = '0;
         after_newline_in = 1'b0;
         halted_in        = 1'b0;
      end

      if (!halted_in) begin
         if (after_newline_in) begin
            after_newline_in = 1'b0;
            cursor_col_in    = '0;
            if (cursor_row_in != tgl_pkg::ROW_MAX) cursor_row_in = cursor_row_in + 9'd1;
         end else if (req_word.code == tgl_pkg::NEWLINE_CODE) begin
            // hold the newline until the next character
            after_newline_in = 1'b1;
            swallow          = 1'b1;
         end

         if (!swallow) begin
            if (cursor_col_in == cfg.columns) begin
               cursor_col_in = '0;
               if (cursor_row_in != tgl_pkg::ROW_MAX) cursor_row_in = cursor_row_in + 9'd1;
            end
            if (cursor_row_in > {1'b0, cfg.row_limit}) begin
               halted_in = 1'b1;
            end else begin
               emit         = 1'b1;
               q_word.glyph = req_word.code - cfg.first_glyph;
               q_word.col   = cursor_col_in;
               q_word.row   = cursor_row_in;
               if (cursor_col_in != tgl_pkg::COL_MAX) cursor_col_in = cursor_col_in + 8'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_col_ff    <= '0;
         cursor_row_ff    <= '0;
         after_newline_ff <= 1'b0;
         halted_ff        <= 1'b0;
      end else if (accept) begin
         cursor_col_ff    <= cursor_col_in;
         cursor_row_ff    <= cursor_row_in;
         after_newline_ff <= after_newline_in;
         halted_ff        <= halted_in;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/tgl_queue.sv -----
// Short word queue between the front end and the back end.
`default_nettype none

module tgl_queue #(
   parameter int Depth = tgl_pkg::QUEUE_DEPTH
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             wr_en,
   input  wire tgl_pkg::work_type wr_word,
   input  wire logic             rd_en,
   output tgl_pkg::work_type     rd_word,
   output tgl_pkg::q_status_type status
);

   localparam int PtrWidth   = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CountWidth = $clog2(Depth + 1);
   localparam logic [PtrWidth-1:0]   PtrLast   = PtrWidth'(Depth - 1);
   localparam logic [CountWidth-1:0] CountFull = CountWidth'(Depth);

   tgl_pkg::work_type      mem_ff [Depth];
   logic [PtrWidth-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CountWidth-1:0]  count_ff, count_in;

   assign status.full  = (count_ff == CountFull);
   assign status.empty = (count_ff == '0);
   assign rd_word      = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (wr_en) wr_ptr_in = (wr_ptr_ff == PtrLast) ? '0 : wr_ptr_ff + PtrWidth'(1);
      if (rd_en) rd_ptr_in = (rd_ptr_ff == PtrLast) ? '0 : rd_ptr_ff + PtrWidth'(1);
      if (wr_en && !rd_en) count_in = count_ff + CountWidth'(1);
      else if (rd_en && !wr_en) count_in = count_ff - CountWidth'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_ptr_ff] <= wr_word;
   end

endmodule

`default_nettype wire

// ----- rtl/tgl_back.sv -----
// Back end: serial glyph index divide, position multiply and result register.
`default_nettype none

module tgl_back (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire tgl_pkg::cfg_type cfg,
   input  wire tgl_pkg::q_status_type q_status,
   input  wire tgl_pkg::work_type q_word,
   output logic                  q_pop,
   input  wire logic             pop,
   output logic                  empty,
   output tgl_pkg::rsp_type      rsp_word
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV,
      ST_MUL,
      ST_HOLD
   } state_type;

   state_type        state_ff;
   logic [2:0]       step_ff;
   logic [7:0]       quot_ff, quot_in;    // dividend shifts out, quotient shifts in
   logic [7:0]       rem_ff, rem_in;
   logic [7:0]       col_ff;
   logic [8:0]       row_ff;
   tgl_pkg::rsp_type rsp_ff;

   logic [8:0]  divisor;
   logic [8:0]  rem_shift;
   logic [14:0] src_x_prod;
   logic [14:0] src_y_prod;
   logic [14:0] dst_x_sum;
   logic [14:0] dst_y_sum;

   assign divisor = (cfg.glyphs_per_row == '0) ? 9'd1 : cfg.glyphs_per_row;
   assign q_pop   = (state_ff == ST_IDLE) & ~q_status.empty;
   assign empty   = (state_ff != ST_HOLD);
   assign rsp_word = rsp_ff;

   // one restoring divide step per cycle
   always_comb begin
      rem_shift = {rem_ff, quot_ff[7]};
      if (rem_shift >= divisor) begin
         rem_in  = 8'(rem_shift - divisor);
         quot_in = {quot_ff[6:0], 1'b1};
      end else begin
         rem_in  = rem_shift[7:0];
         quot_in = {quot_ff[6:0], 1'b0};
      end
   end

   assign src_x_prod = 15'(rem_ff) * 15'(cfg.char_width);
   assign src_y_prod = 15'(quot_ff) * 15'(cfg.char_height);
   assign dst_x_sum  = 15'(col_ff) * 15'(cfg.char_width) + 15'(cfg.origin_x);
   assign dst_y_sum  = 15'(row_ff) * 15'(cfg.char_height) + 15'(cfg.origin_y);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               step_ff <= '0;
               if (!q_status.empty) state_ff <= ST_DIV;
            end
            ST_DIV: begin
               step_ff <= step_ff + 3'd1;
               if (step_ff == 3'd7) state_ff <= ST_MUL;
            end
            ST_MUL: begin
               state_ff <= ST_HOLD;
            end
            ST_HOLD: begin
               if (pop) state_ff <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         quot_ff <= q_word.glyph;
         rem_ff  <= '0;
         col_ff  <= q_word.col;
         row_ff  <= q_word.row;
      end else if (state_ff == ST_DIV) begin
         quot_ff <= quot_in;
         rem_ff  <= rem_in;
      end
      if (state_ff == ST_MUL) begin
         rsp_ff.src_x <= src_x_prod[13:0];
         rsp_ff.src_y <= src_y_prod[13:0];
         rsp_ff.dst_x <= dst_x_sum;
         rsp_ff.dst_y <= dst_y_sum;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/text_glyph_layout.sv -----
// Top level of the text glyph layout block: CSRs, front end, queue, back end.
// A drawn character passes through the queue, the 8-step serial divide of its glyph index in the
// back end and the multiply step before it shows on the result port; the back end takes a new
// character only after the last result is taken. Characters that draw nothing never reach the queue.
// The front end keeps accepting while the back end works, until the queue fills.
// Reset (synchronous, active high) restores register defaults, clears cursor and queue.
`default_nettype none

module text_glyph_layout #(
   parameter int QueueDepth = tgl_pkg::QUEUE_DEPTH
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // input word channel
   input  wire logic                            push,
   output logic                                 full,
   input  wire tgl_pkg::req_type                req_word,
   // result word channel
   output logic                                 empty,
   input  wire logic                            pop,
   output tgl_pkg::rsp_type                     rsp_word,
   // configuration port
   input  wire logic                            psel,
   input  wire logic                            penable,
   input  wire logic                            pwrite,
   input  wire logic [tgl_pkg::PADDR_WIDTH-1:0] paddr,
   input  wire logic [tgl_pkg::PDATA_WIDTH-1:0] pwdata,
   output logic      [tgl_pkg::PDATA_WIDTH-1:0] prdata,
   output logic                                 pready
);

   tgl_pkg::cfg_type      cfg;
   tgl_pkg::q_status_type q_status;
   tgl_pkg::work_type     q_wr_word;
   tgl_pkg::work_type     q_rd_word;
   logic                  q_push;
   logic                  q_pop;

   // Register file read directly by the block; users must do writes only while idle, not enforced.
   tgl_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // Front end: advance the cursor per character, drop newlines (but not one right after a
   // newline) and halted text, push one word per glyph that gets drawn.
   tgl_front u_front (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .push     (push),
      .req_word (req_word),
      .q_status (q_status),
      .q_push   (q_push),
      .q_word   (q_wr_word)
   );

   // Hold input back only when the queue to the back end is full.
   assign full = q_status.full;

   tgl_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (q_push),
      .wr_word (q_wr_word),
      .rd_en   (q_pop),
      .rd_word (q_rd_word),
      .status  (q_status)
   );

   // Back end: divide glyph index by sheet width, scale to pixels, hold the result
   // in its output register until taken.
   tgl_back u_back (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .q_status (q_status),
      .q_word   (q_rd_word),
      .q_pop    (q_pop),
      .pop      (pop),
      .empty    (empty),
      .rsp_word (rsp_word)
   );

   // The front end never writes a full queue.
   assert property (@(posedge clock) disable iff (reset) q_push |-> !q_status.full)
      else $error("queue written while full");

   // The back end never reads an empty queue.
   assert property (@(posedge clock) disable iff (reset) q_pop |-> !q_status.empty)
      else $error("queue read while empty");

   // No result is offered right after reset.
   assert property (@(posedge clock) $past(reset) |-> empty)
      else $error("result offered after reset");

   // A taken result frees the output register on the next edge.
   assert property (@(posedge clock) disable iff (reset) (pop && !empty) |=> empty)
      else $error("result register not released after pop");

endmodule

`default_nettype wire

// ----- tb/sv/testbench.sv -----
// Self-checking testbench for text_glyph_layout: directed glyph cases, then random texts.
module testbench;
   import tgl_pkg::*;

   // Clock and reset.
   logic clock = 1'b0;
   logic reset;

   always #2 clock = ~clock;

   // Block ports.
   logic                   push;
   logic                   full;
   req_type                req_word;
   logic                   empty;
   logic                   pop;
   rsp_type                rsp_word;
   logic                   psel;
   logic                   penable;
   logic                   pwrite;
   logic [PADDR_WIDTH-1:0] paddr;
   logic [PDATA_WIDTH-1:0] pwdata;
   logic [PDATA_WIDTH-1:0] prdata;
   logic                   pready;

   text_glyph_layout u_dut (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .full     (full),
      .req_word (req_word),
      .empty    (empty),
      .pop      (pop),
      .rsp_word (rsp_word),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   // Shadow of the register file and of the cursor, as the layout logic should hold them.
   cfg_type    regs;
   logic [7:0] cur_col;
   logic [8:0] cur_row;
   logic       nl_pending;
   logic       stopped;

   // Glyph placements still owed by the block, oldest first.
   rsp_type glyphs_due[$];

   int n_errors   = 0;
   int n_sent     = 0;
   int n_checked  = 0;
   int n_settings = 0;

   // Per-side idling: when steady, a side never idles; it flips now and then.
   bit steady_in  = 1'b0;
   bit steady_out = 1'b0;

   function automatic int pick_gap(input bit steady);
      return steady ? 0 : int'($urandom_range(0, 16));
   endfunction

   // Move the cursor to column 0 of the next row; the row counter saturates.
   function automatic void next_row();
      cur_col = '0;
      if (cur_row != ROW_MAX) cur_row = cur_row + 9'd1;
   endfunction

   // Advance the cursor for one character word and work out the glyph it draws, if any.
   function automatic bit place_glyph(input req_type w, output rsp_type r);
      int unsigned glyph;
      int unsigned per_row;
      int unsigned sum;
      r = '0;
      // A new text clears cursor, pending newline and the stop mark first.
      if (w.text_start) begin
         cur_col    = '0;
         cur_row    = '0;
         nl_pending = 1'b0;
         stopped    = 1'b0;
      end
      if (stopped) return 1'b0;
      // The character after a newline is drawn, even a newline, unless past the row limit.
      if (nl_pending) begin
         nl_pending = 1'b0;
         next_row();
      end else if (w.code == NEWLINE_CODE) begin
         nl_pending = 1'b1;
         return 1'b0;
      end
      if (cur_col == regs.columns) next_row();
      if (cur_row > {1'b0, regs.row_limit}) begin
         stopped = 1'b1;
         return 1'b0;
      end
      // Glyph index wraps modulo 256 for codes below the first glyph.
      glyph   = 8'(w.code - regs.first_glyph);
      per_row = (regs.glyphs_per_row == '0) ? 1 : regs.glyphs_per_row;
      sum = (glyph % per_row) * regs.char_width;
      r.src_x = sum[13:0];
      sum = (glyph / per_row) * regs.char_height;
      r.src_y = sum[13:0];
      sum = regs.origin_x + cur_col * regs.char_width;
      r.dst_x = sum[14:0];
      sum = regs.origin_y + cur_row * regs.char_height;
      r.dst_y = sum[14:0];
      if (cur_col != COL_MAX) cur_col = cur_col + 8'd1;
      return 1'b1;
   endfunction

   function automatic logic [31:0] reg_value(input csr_addr_type idx);
      case (idx)
         CSR_CHAR_WIDTH:     return 32'(regs.char_width);
         CSR_CHAR_HEIGHT:    return 32'(regs.char_height);
         CSR_GLYPHS_PER_ROW: return 32'(regs.glyphs_per_row);
         CSR_ORIGIN_X:       return 32'(regs.origin_x);
         CSR_ORIGIN_Y:       return 32'(regs.origin_y);
         CSR_COLUMNS:        return 32'(regs.columns);
         CSR_ROW_LIMIT:      return 32'(regs.row_limit);
         default:            return 32'(regs.first_glyph);
      endcase
   endfunction

   // One APB transfer: setup cycle, access cycle, then a cycle with the bus parked.
   // Starts and ends at a falling edge.
   task automatic csr_cycle(input bit is_write, input csr_addr_type idx,
                            input logic [31:0] wdata, output logic [31:0] rdata);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= is_write;
      paddr   <= {idx, 2'b00};
      pwdata  <= wdata;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      rdata = prdata;
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(negedge clock);
   endtask

   task automatic check_reg(input csr_addr_type idx);
      logic [31:0] got;
      csr_cycle(1'b0, idx, '0, got);
      if (got !== reg_value(idx)) begin
         n_errors++;
         $display("%0t: register %s read expected %0d, got %0d",
                  $time, idx.name(), reg_value(idx), got);
      end
   endtask

   // Write a register, mirror it in the shadow, and read it back.
   task automatic write_reg(input csr_addr_type idx, input logic [31:0] value);
      logic [31:0] unused;
      csr_cycle(1'b1, idx, value, unused);
      case (idx)
         CSR_CHAR_WIDTH:     regs.char_width     = value[6:0];
         CSR_CHAR_HEIGHT:    regs.char_height    = value[6:0];
         CSR_GLYPHS_PER_ROW: regs.glyphs_per_row = value[8:0];
         CSR_ORIGIN_X:       regs.origin_x       = value[11:0];
         CSR_ORIGIN_Y:       regs.origin_y       = value[11:0];
         CSR_COLUMNS:        regs.columns        = value[7:0];
         CSR_ROW_LIMIT:      regs.row_limit      = value[7:0];
         default:            regs.first_glyph    = value[7:0];
      endcase
      check_reg(idx);
   endtask

   // Load all eight registers in one go; counts as one new setting.
   task automatic load_layout(input int cw, input int ch, input int gpr, input int ox,
                              input int oy, input int cols, input int rlim, input int fg);
      write_reg(CSR_CHAR_WIDTH, cw);
      write_reg(CSR_CHAR_HEIGHT, ch);
      write_reg(CSR_GLYPHS_PER_ROW, gpr);
      write_reg(CSR_ORIGIN_X, ox);
      write_reg(CSR_ORIGIN_Y, oy);
      write_reg(CSR_COLUMNS, cols);
      write_reg(CSR_ROW_LIMIT, rlim);
      write_reg(CSR_FIRST_GLYPH, fg);
      n_settings++;
   endtask

   // Offer one character word and predict on acceptance. Starts and ends at a
   // falling edge, leaving push high so a back-to-back word needs no second drive.
   task automatic send_char(input logic [7:0] code, input logic start);
      req_type w;
      rsp_type r;
      int      gap;
      w.code       = code;
      w.text_start = start;
      if ($urandom_range(0, 39) == 0) steady_in = !steady_in;
      gap = pick_gap(steady_in);
      if (gap != 0) begin
         push <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      push     <= 1'b1;
      req_word <= w;
      @(posedge clock);
      while (full) @(posedge clock);
      if (place_glyph(w, r)) glyphs_due.push_back(r);
      n_sent++;
      @(negedge clock);
   endtask

   // Drop push, let every owed glyph come out, then hold long enough for a
   // word that draws nothing to clear the pipeline before registers change.
   task automatic drain();
      push <= 1'b0;
      for (int t = 0; t < 4000 && glyphs_due.size() != 0; t++) @(negedge clock);
      if (glyphs_due.size() != 0) begin
         n_errors++;
         $display("%0t: %0d glyph results never arrived", $time, glyphs_due.size());
         glyphs_due.delete();
      end
      repeat (40) @(negedge clock);
   endtask

   // Directed: register defaults, wrapped glyph indices, newline handling,
   // wrap and stop at the row limit, and extreme register values.
   task automatic test_directed();
      for (int i = 0; i < 8; i++) check_reg(csr_addr_type'(i));
      send_char(8'd65, 1'b1);
      send_char(8'd0, 1'b0);            // below first glyph: index wraps
      send_char(8'd255, 1'b0);
      send_char(8'd31, 1'b0);
      send_char(NEWLINE_CODE, 1'b0);    // newline alone draws nothing
      send_char(8'd66, 1'b0);
      send_char(NEWLINE_CODE, 1'b0);
      send_char(NEWLINE_CODE, 1'b0);    // newline right after newline is drawn
      send_char(NEWLINE_CODE, 1'b0);    // left pending at the end of the text
      send_char(8'd67, 1'b1);
      drain();
      // Two columns, single row: the third character wraps past the limit and stops.
      load_layout(1, 1, 1, 0, 0, 2, 0, 0);
      send_char(8'd97, 1'b1);
      send_char(8'd98, 1'b0);
      send_char(8'd99, 1'b0);
      send_char(8'd100, 1'b0);          // stopped: ignored
      send_char(8'd101, 1'b1);          // new text resumes
      send_char(NEWLINE_CODE, 1'b0);
      send_char(8'd102, 1'b0);
      drain();
      // Widest cells, far origin, zero glyphs per row: positions wrap at field width.
      load_layout(127, 127, 0, 4095, 4095, 255, 255, 255);
      send_char(8'd254, 1'b1);
      send_char(8'd0, 1'b0);
      send_char(NEWLINE_CODE, 1'b0);
      send_char(8'd255, 1'b0);
      drain();
      load_layout(64, 64, 511, 4095, 0, 0, 255, 0);
      send_char(8'd255, 1'b1);
      send_char(8'd128, 1'b0);
      drain();
      load_layout(1, 64, 256, 0, 4095, 1, 0, 128);
      send_char(8'd127, 1'b1);
      send_char(8'd129, 1'b0);
      drain();
   endtask

   // Random: mostly well-formed texts with random content, some stray words.
   task automatic test_random_texts(input int n_words, input int max_len, input int nl_odds);
      int start_count;
      int len;
      logic [7:0] code;
      start_count = n_sent;
      while (n_sent - start_count < n_words) begin
         if ($urandom_range(0, 99) < 85) begin
            len = $urandom_range(1, max_len);
            for (int k = 0; k < len; k++) begin
               code = ($urandom_range(0, nl_odds) == 0) ? NEWLINE_CODE
                                                        : 8'($urandom_range(0, 255));
               send_char(code, k == 0);
            end
         end else begin
            send_char(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
         end
      end
      drain();
   endtask

   // Random settings: alternate between small grids that wrap and stop often,
   // and full-width values including zero.
   task automatic test_random_settings();
      for (int p = 0; p < 6; p++) begin
         if (p % 2 == 0)
            load_layout($urandom_range(1, 64), $urandom_range(1, 64),
                        $urandom_range(1, 256), $urandom_range(0, 4095),
                        $urandom_range(0, 4095), $urandom_range(1, 24),
                        $urandom_range(0, 12), $urandom_range(0, 255));
         else
            load_layout($urandom_range(0, 127), $urandom_range(0, 127),
                        $urandom_range(0, 511), $urandom_range(0, 4095),
                        $urandom_range(0, 4095), $urandom_range(0, 255),
                        $urandom_range(0, 255), $urandom_range(0, 255));
         test_random_texts(50, 40, 7);
      end
   endtask

   // Zero columns: the column counter runs up to its ceiling and sticks there.
   task automatic test_long_rows();
      load_layout(1, 1, 1, 0, 0, 0, 255, $urandom_range(0, 255));
      test_random_texts(270, 300, 200);
   endtask

   // Result side: draw a stall per word, then pop and check against the oldest expectation.
   task automatic compare_field(input string name, input int exp, input int act);
      if (exp != act) begin
         n_errors++;
         $display("%0t: %s expected %0d, got %0d", $time, name, exp, act);
      end
   endtask

   initial begin
      rsp_type exp;
      int      stall;
      pop = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if ($urandom_range(0, 39) == 0) steady_out = !steady_out;
         stall = pick_gap(steady_out);
         if (stall != 0) begin
            pop <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         pop <= 1'b1;
         @(posedge clock);
         while (empty) @(posedge clock);
         if (glyphs_due.size() == 0) begin
            n_errors++;
            $display("%0t: glyph result with none expected, got %p", $time, rsp_word);
         end else begin
            exp = glyphs_due.pop_front();
            compare_field("src_x", exp.src_x, rsp_word.src_x);
            compare_field("src_y", exp.src_y, rsp_word.src_y);
            compare_field("dst_x", exp.dst_x, rsp_word.dst_x);
            compare_field("dst_y", exp.dst_y, rsp_word.dst_y);
            n_checked++;
         end
         @(negedge clock);
      end
   end

   // Main sequence: reset once, then each test in turn.
   initial begin
      reset    = 1'b1;
      push     = 1'b0;
      req_word = '0;
      psel     = 1'b0;
      penable  = 1'b0;
      pwrite   = 1'b0;
      paddr    = '0;
      pwdata   = '0;
      regs = '{char_width: CHAR_WIDTH_RESET, char_height: CHAR_HEIGHT_RESET,
               glyphs_per_row: GLYPHS_PER_ROW_RESET, origin_x: ORIGIN_X_RESET,
               origin_y: ORIGIN_Y_RESET, columns: COLUMNS_RESET,
               row_limit: ROW_LIMIT_RESET, first_glyph: FIRST_GLYPH_RESET};
      cur_col    = '0;
      cur_row    = '0;
      nl_pending = 1'b0;
      stopped    = 1'b0;
      repeat (5) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_directed();
      test_random_settings();
      test_long_rows();

      $display("Sent %0d character words over %0d register settings plus defaults;",
               n_sent, n_settings);
      $display("checked %0d glyph placements, %0d mismatches.", n_checked, n_errors);
      if (n_errors == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // Hard stop in case a handshake hangs.
   initial begin
      #2000000;
      $display("Timed out waiting for the block");
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

// ----- filelist.f -----
rtl/tgl_pkg.sv
rtl/tgl_csr.sv
rtl/tgl_front.sv
rtl/tgl_queue.sv
rtl/tgl_back.sv
rtl/text_glyph_layout.sv
tb/sv/testbench.sv
